FILE: rtl/core/tep_pkg.sv
`timescale 1ns / 1ps

package tep_pkg;

  localparam int SYM_W      = 6;
  localparam int SHIFT_W    = 18;
  localparam int MAX_BYTES  = 6;
  localparam int NB_W       = 3;
  localparam int FIFO_DEPTH = 16;

  localparam logic [SYM_W-1:0] SYM_ESCAPE     = 6'd62;
  localparam logic [SYM_W-1:0] SYM_SPACE      = 6'd63;
  localparam logic [SYM_W-1:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [SYM_W-1:0] SYM_DIGIT_BASE = 6'd52;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_SYM  = 2'd0,  // direct symbol
    KIND_ESC1 = 2'd1,  // escape + letter
    KIND_ESC2 = 2'd2,  // escape, escape + letter
    KIND_BAD  = 2'd3   // not encodable
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] sym;  // symbol, or table index for escapes
  } class_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [1:0]         cnt;
    logic [4:0]         held_k;
    logic               held_v;
  } tep_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } tep_entry_t;

  function automatic class_t tep_classify(input logic [7:0] c);
    class_t r;
    r.kind = KIND_BAD;
    r.sym  = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.kind = KIND_SYM;
      r.sym  = SYM_W'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.kind = KIND_SYM;
      r.sym  = SYM_W'(c - 8'h61) + SYM_LOWER_BASE;
    end else if (c inside {[8'h30:8'h39]}) begin
      r.kind = KIND_SYM;
      r.sym  = SYM_W'(c - 8'h30) + SYM_DIGIT_BASE;
    end else if (c == CHAR_SPACE) begin
      r.kind = KIND_SYM;
      r.sym  = SYM_SPACE;
    end else begin
      case (c)
        // first escape table: @ $ _ ! " # % & ' ( ) * + , - . / : ; < = > ? LF
        8'h40: begin r.kind = KIND_ESC1; r.sym = 6'd0;  end
        8'h24: begin r.kind = KIND_ESC1; r.sym = 6'd1;  end
        8'h5F: begin r.kind = KIND_ESC1; r.sym = 6'd2;  end
        8'h21: begin r.kind = KIND_ESC1; r.sym = 6'd3;  end
        8'h22: begin r.kind = KIND_ESC1; r.sym = 6'd4;  end
        8'h23: begin r.kind = KIND_ESC1; r.sym = 6'd5;  end
        8'h25: begin r.kind = KIND_ESC1; r.sym = 6'd6;  end
        8'h26: begin r.kind = KIND_ESC1; r.sym = 6'd7;  end
        8'h27: begin r.kind = KIND_ESC1; r.sym = 6'd8;  end
        8'h28: begin r.kind = KIND_ESC1; r.sym = 6'd9;  end
        8'h29: begin r.kind = KIND_ESC1; r.sym = 6'd10; end
        8'h2A: begin r.kind = KIND_ESC1; r.sym = 6'd11; end
        8'h2B: begin r.kind = KIND_ESC1; r.sym = 6'd12; end
        8'h2C: begin r.kind = KIND_ESC1; r.sym = 6'd13; end
        8'h2D: begin r.kind = KIND_ESC1; r.sym = 6'd14; end
        8'h2E: begin r.kind = KIND_ESC1; r.sym = 6'd15; end
        8'h2F: begin r.kind = KIND_ESC1; r.sym = 6'd16; end
        8'h3A: begin r.kind = KIND_ESC1; r.sym = 6'd17; end
        8'h3B: begin r.kind = KIND_ESC1; r.sym = 6'd18; end
        8'h3C: begin r.kind = KIND_ESC1; r.sym = 6'd19; end
        8'h3D: begin r.kind = KIND_ESC1; r.sym = 6'd20; end
        8'h3E: begin r.kind = KIND_ESC1; r.sym = 6'd21; end
        8'h3F: begin r.kind = KIND_ESC1; r.sym = 6'd22; end
        8'h0A: begin r.kind = KIND_ESC1; r.sym = 6'd23; end
        // second escape table: [ \ ] ^ { | } ~ ` TAB
        8'h5B: begin r.kind = KIND_ESC2; r.sym = 6'd0;  end
        8'h5C: begin r.kind = KIND_ESC2; r.sym = 6'd1;  end
        8'h5D: begin r.kind = KIND_ESC2; r.sym = 6'd2;  end
        8'h5E: begin r.kind = KIND_ESC2; r.sym = 6'd3;  end
        8'h7B: begin r.kind = KIND_ESC2; r.sym = 6'd4;  end
        8'h7C: begin r.kind = KIND_ESC2; r.sym = 6'd5;  end
        8'h7D: begin r.kind = KIND_ESC2; r.sym = 6'd6;  end
        8'h7E: begin r.kind = KIND_ESC2; r.sym = 6'd7;  end
        8'h60: begin r.kind = KIND_ESC2; r.sym = 6'd8;  end
        8'h09: begin r.kind = KIND_ESC2; r.sym = 6'd9;  end
        default: begin r.kind = KIND_BAD; r.sym = '0; end
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tep_encode.sv
`timescale 1ns / 1ps

module tep_encode (
  input  logic                                       in_v,
  input  logic [7:0]                                 in_char,
  input  logic                                       in_last,
  input  tep_pkg::tep_state_t                        st,
  output tep_pkg::tep_state_t                        st_nxt,
  output logic [tep_pkg::NB_W-1:0]                   nbytes,
  output tep_pkg::tep_entry_t [tep_pkg::MAX_BYTES-1:0] ents
);

  tep_pkg::class_t           cls;
  logic [5:0]                sy [4];
  logic [2:0]                n;
  logic                      held_v;
  logic [4:0]                held_k;
  logic [47:0]               acc;
  logic [47:0]               words;
  logic [3:0]                cnt;
  logic [1:0]                grp;
  logic [1:0]                rem;
  logic [tep_pkg::SHIFT_W-1:0] rem_bits;

  always_comb begin
    cls    = tep_pkg::tep_classify(in_char);
    sy     = '{default: '0};
    n      = '0;
    held_v = st.held_v;
    held_k = st.held_k;

    // symbol list for this byte, in order
    if (in_char == tep_pkg::CHAR_SPACE && st.held_v) begin
      // space folds into the held letter: send it uppercase
      sy[0]  = {1'b0, held_k};
      n      = 3'd1;
      held_v = 1'b0;
    end else begin
      if (held_v) begin
        sy[n[1:0]] = tep_pkg::SYM_LOWER_BASE + {1'b0, held_k};
        n          = n + 3'd1;
        held_v     = 1'b0;
      end
      case (cls.kind)
        tep_pkg::KIND_SYM: begin
          sy[n[1:0]] = cls.sym;
          n          = n + 3'd1;
        end
        tep_pkg::KIND_ESC1: begin
          sy[n[1:0]] = tep_pkg::SYM_ESCAPE;
          n          = n + 3'd1;
          held_k     = cls.sym[4:0];
          held_v     = 1'b1;
        end
        tep_pkg::KIND_ESC2: begin
          sy[n[1:0]] = tep_pkg::SYM_ESCAPE;
          n          = n + 3'd1;
          sy[n[1:0]] = tep_pkg::SYM_ESCAPE;
          n          = n + 3'd1;
          held_k     = cls.sym[4:0];
          held_v     = 1'b1;
        end
        default: ;
      endcase
    end
    if (in_last && held_v) begin
      sy[n[1:0]] = tep_pkg::SYM_LOWER_BASE + {1'b0, held_k};
      n          = n + 3'd1;
      held_v     = 1'b0;
    end

    // append to the waiting symbols, then pad at end of message
    acc = {30'd0, st.shift};
    cnt = {2'b00, st.cnt};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < n) begin
        acc = {acc[41:0], sy[i]};
        cnt = cnt + 4'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (in_last && cnt[1:0] != 2'd0) begin
        acc = {acc[41:0], tep_pkg::SYM_SPACE};
        cnt = cnt + 4'd1;
      end
    end
    grp = cnt[3:2];
    rem = cnt[1:0];

    case (rem)
      2'd0:    begin words = acc;                 rem_bits = '0;                  end
      2'd1:    begin words = {6'd0,  acc[47:6]};  rem_bits = {12'd0, acc[5:0]};   end
      2'd2:    begin words = {12'd0, acc[47:12]}; rem_bits = {6'd0,  acc[11:0]};  end
      default: begin words = {18'd0, acc[47:18]}; rem_bits = acc[17:0];           end
    endcase

    ents = '0;
    if (grp == 2'd2) begin
      ents[0].data = words[47:40];
      ents[1].data = words[39:32];
      ents[2].data = words[31:24];
      ents[3].data = words[23:16];
      ents[4].data = words[15:8];
      ents[5].data = words[7:0];
      nbytes       = 3'd6;
    end else if (grp == 2'd1) begin
      ents[0].data = words[23:16];
      ents[1].data = words[15:8];
      ents[2].data = words[7:0];
      nbytes       = 3'd3;
    end else begin
      nbytes       = 3'd0;
    end

    st_nxt.shift  = rem_bits;
    st_nxt.cnt    = rem;
    st_nxt.held_k = held_k;
    st_nxt.held_v = held_v;

    if (cls.kind == tep_pkg::KIND_BAD) begin
      // abort: one error item, state cleared
      ents         = '0;
      ents[0].last = 1'b1;
      ents[0].err  = 1'b1;
      nbytes       = 3'd1;
      st_nxt       = '0;
    end else if (in_last) begin
      if (nbytes == 3'd6) ents[5].last = 1'b1;
      else                ents[2].last = 1'b1;
      st_nxt = '0;
    end

    if (!in_v) begin
      nbytes = '0;
      st_nxt = st;
    end
  end

endmodule

FILE: rtl/core/tep_fifo.sv
`timescale 1ns / 1ps

module tep_fifo #(
  parameter int DEPTH = tep_pkg::FIFO_DEPTH
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [tep_pkg::NB_W-1:0]                     wr_n,
  input  tep_pkg::tep_entry_t [tep_pkg::MAX_BYTES-1:0] wr_ents,
  input  logic                                         rd_en,
  output tep_pkg::tep_entry_t                          rd_ent,
  output logic                                         rd_v,
  output logic                                         room,
  output logic [$clog2(DEPTH+1)-1:0]                   level
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int NB_W = tep_pkg::NB_W;

  tep_pkg::tep_entry_t mem [DEPTH];
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                rd_fire;

  assign rd_v    = cnt_r != '0;
  assign rd_fire = rd_en && rd_v;
  assign rd_ent  = mem[rd_ptr_r];
  assign room    = cnt_r <= CW'(DEPTH - tep_pkg::MAX_BYTES);
  assign level   = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(wr_n);
    rd_ptr_nxt = rd_ptr_r + AW'(rd_fire);
    cnt_nxt    = cnt_r + CW'(wr_n) - CW'(rd_fire);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tep_pkg::MAX_BYTES; i++) begin
      if (NB_W'(i) < wr_n) begin
        mem[wr_ptr_r + AW'(i)] <= wr_ents[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/text_escape_pack_encoder.sv
`timescale 1ns / 1ps

// Channel  | ports                          | fields (low bit up)
// ---------+--------------------------------+------------------------------
// input    | in_tvalid/in_tready/in_tdata   | tdata[7:0] message byte,
//          | in_tlast                       | tlast = final byte of message
// output   | out_tvalid/out_tready/out_tdata| tdata[7:0] packed byte,
//          | out_tlast, out_tuser           | tlast = final byte or error,
//          |                                | tuser[0] = error
//
// One byte enters per cycle. It is registered, encoded in a single pass
// (class lookup, escape hold, 4-symbol packing, end-of-message pad) and its
// 0..6 result bytes go into a byte FIFO that drains one item per cycle
// while out_tready is high; an item passes the stage, then the FIFO.
// The input stalls only while the FIFO has fewer than six free slots. Direct
// symbols average 3/4 byte per item, so plain text keeps one item per cycle;
// escapes make 1.5 or 2.25 bytes and long runs of them, like end-of-message
// flushes, throttle the input to the one-byte-per-cycle output rate.
// Reset (rst_n low, synchronous) clears the stage, packing state and FIFO.
// FIFO_DEPTH must be a power of two of at least 8.

module text_escape_pack_encoder #(
  parameter int FIFO_DEPTH = tep_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,
  output logic [0:0] out_tuser    // [0] out_error
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // input register stage
  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_char_r;
  logic       stg_last_r;
  logic       in_fire;
  logic       stg_fire;

  // packing state
  tep_pkg::tep_state_t st_r, st_nxt;

  tep_pkg::tep_entry_t [tep_pkg::MAX_BYTES-1:0] ents;
  logic [tep_pkg::NB_W-1:0] nbytes;
  tep_pkg::tep_entry_t      rd_ent;
  logic                     room;
  logic [CW-1:0]            level;

  assign stg_fire  = stg_v_r && room;
  assign in_tready = !stg_v_r || room;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (stg_fire) stg_v_nxt = 1'b0;
    if (in_fire)  stg_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      stg_v_r <= stg_v_nxt;
      st_r    <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_char_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  tep_encode u_encode (
    .in_v    (stg_fire),
    .in_char (stg_char_r),
    .in_last (stg_last_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .nbytes  (nbytes),
    .ents    (ents)
  );

  tep_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_n    (nbytes),
    .wr_ents (ents),
    .rd_en   (out_tready),
    .rd_ent  (rd_ent),
    .rd_v    (out_tvalid),
    .room    (room),
    .level   (level)
  );

  assign out_tdata = rd_ent.data;
  assign out_tlast = rd_ent.last;
  assign out_tuser = rd_ent.err;

  // an error item always closes the message
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("error item without tlast");

  // end of message leaves no symbols or held letter behind
  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    stg_fire && stg_last_r |=> st_r.cnt == 2'd0 && !st_r.held_v)
    else $error("state not cleared after last byte");

  // FIFO never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    level <= CW'(FIFO_DEPTH))
    else $error("output FIFO overflow");

  // a blocked staged byte is kept
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && !room |=> stg_v_r && $stable(stg_char_r) && $stable(stg_last_r))
    else $error("staged byte lost while blocked");

endmodule
